[src/cep_pkg.sv]
// ----------------------------------------------------------------------------
// cep_pkg: shared types and constants for the epicycle position block
// Field widths, register indexes, CORDIC lane type and arctangent table.
// ----------------------------------------------------------------------------
package cep_pkg;

  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 64;
  localparam int TimeW     = 32;
  localparam int IdW       = 6;
  localparam int CoordW    = 16;
  localparam int NcW       = 4;
  localparam int DcW       = 7;
  localparam int PerW      = 7;
  localparam int PnumW     = 8;   // dc + nc - 1
  localparam int RadW      = 23;  // r2 * 8 + radius_offset * id
  localparam int LenProdW  = 23;  // index * length
  localparam int PhNumW    = LenProdW + 17;
  localparam int CordW     = 32;
  localparam int ZW        = 16;
  localparam int CordicSteps = 14;
  localparam int TsW       = 29;
  localparam int AccW      = 64;
  localparam int CenOffW   = 24;

  localparam logic signed [CordW-1:0] CordicGain = 32'sd652032874;

  typedef enum logic [CfgIdxW-1:0] {
    REG_NUM_CIRCLES   = 3'd0,
    REG_DRONE_COUNT   = 3'd1,
    REG_CENTER_XYZ    = 3'd2,
    REG_BIG_CIRCLE    = 3'd3,
    REG_SMALL_CIRCLE  = 3'd4,
    REG_ID_OFFSET_XYZ = 3'd5,
    REG_RADIUS_OFFSET = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic signed [CordW-1:0] x;
    logic signed [CordW-1:0] y;
    logic signed [ZW-1:0]    z;
  } cordic_lane_t;

  // Arctangent of 2^-i in units of 2^-16 turns
  function automatic logic signed [ZW-1:0] atan_turns(input int step);
    logic signed [ZW-1:0] r;
    case (step)
      0:       r = 16'sd8192;
      1:       r = 16'sd4836;
      2:       r = 16'sd2555;
      3:       r = 16'sd1297;
      4:       r = 16'sd651;
      5:       r = 16'sd326;
      6:       r = 16'sd163;
      7:       r = 16'sd81;
      8:       r = 16'sd41;
      9:       r = 16'sd20;
      10:      r = 16'sd10;
      11:      r = 16'sd5;
      12:      r = 16'sd3;
      13:      r = 16'sd1;
      default: r = 16'sd0;
    endcase
    return r;
  endfunction

  // Floor value in bits 26:0 clamped to signed 16 bits
  function automatic logic signed [CoordW-1:0] sat16(input logic signed [26:0] v);
    logic signed [CoordW-1:0] r;
    if (!v[26] && (|v[25:15])) begin
      r = 16'sh7FFF;
    end else if (v[26] && !(&v[25:15])) begin
      r = 16'sh8000;
    end else begin
      r = v[CoordW-1:0];
    end
    return r;
  endfunction

endpackage

[src/circle_epicycle_position.sv]
// ----------------------------------------------------------------------------
// circle_epicycle_position: drone target on a circle-of-circles pattern
// Pipelined divider and CORDIC cell chains turn (time, id) into x,y,z Q8.8.
// ----------------------------------------------------------------------------
//  channel  | signals                                  | direction
//  ---------+------------------------------------------+----------
//  command  | start_i, busy_o, time_seconds_i, drone_id_i | in (busy_o out)
//  result   | valid_o, pos_x_o, pos_y_o, pos_z_o        | out
//  config   | cfg_we_i, cfg_idx_i, cfg_wdata_i          | in
//
//  One transaction per cycle.
//  Latency is set by the division chains (8 + 6 + 40 cells), the 14 CORDIC
//  cells and the multiply/accumulate/round stages.
//  Reset clears all valid flags; configuration returns to its defaults.
//  busy_o is never raised and results are never held back.
// ----------------------------------------------------------------------------
module circle_epicycle_position #(
  parameter int MAX_DRONES  = 64,
  parameter int MAX_CIRCLES = 10
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic [cep_pkg::TimeW-1:0]          time_seconds_i,
  input  logic [cep_pkg::IdW-1:0]            drone_id_i,
  output logic                               valid_o,
  output logic signed [cep_pkg::CoordW-1:0]  pos_x_o,
  output logic signed [cep_pkg::CoordW-1:0]  pos_y_o,
  output logic signed [cep_pkg::CoordW-1:0]  pos_z_o,
  input  logic                               cfg_we_i,
  input  logic [cep_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [cep_pkg::CfgDataW-1:0]       cfg_wdata_i
);
  import cep_pkg::*;

  localparam int Latency = PnumW + IdW + 1 + PhNumW + 2 + CordicSteps + 4;
  localparam logic signed [AccW-1:0] RoundBias = 64'sd1 <<< 36;

  // ---------------- configuration registers ----------------
  logic [NcW-1:0]      nc_q;
  logic [DcW-1:0]      dc_q;
  logic [47:0]         center_q;
  logic [63:0]         big_q;
  logic [63:0]         small_q;
  logic [47:0]         idoff_q;
  logic signed [15:0]  rad_off_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nc_q      <= 4'd1;
      dc_q      <= 7'd1;
      center_q  <= 48'h0000_0080_0000;
      big_q     <= 64'h8000_0000_0000_0000;
      small_q   <= 64'h8000_0333_0000_04CD;
      idoff_q   <= '0;
      rad_off_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_NUM_CIRCLES:   nc_q      <= cfg_wdata_i[NcW-1:0];
        REG_DRONE_COUNT:   dc_q      <= cfg_wdata_i[DcW-1:0];
        REG_CENTER_XYZ:    center_q  <= cfg_wdata_i[47:0];
        REG_BIG_CIRCLE:    big_q     <= cfg_wdata_i;
        REG_SMALL_CIRCLE:  small_q   <= cfg_wdata_i;
        REG_ID_OFFSET_XYZ: idoff_q   <= cfg_wdata_i[47:0];
        REG_RADIUS_OFFSET: rad_off_q <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  logic [15:0]        r1, r2, start1, start2, len1, len2;
  logic signed [15:0] speed1, speed2;
  logic [NcW-1:0]     nc_eff;
  logic [DcW-1:0]     dc_eff;

  always_comb begin
    r1     = big_q[15:0];
    start1 = big_q[31:16];
    speed1 = big_q[47:32];
    len1   = big_q[63:48];
    r2     = small_q[15:0];
    start2 = small_q[31:16];
    speed2 = small_q[47:32];
    len2   = small_q[63:48];
    if (nc_q == '0) begin
      nc_eff = NcW'(1);
    end else if (32'(nc_q) > MAX_CIRCLES) begin
      nc_eff = NcW'(MAX_CIRCLES);
    end else begin
      nc_eff = nc_q;
    end
    dc_eff = (32'(dc_q) > MAX_DRONES) ? DcW'(MAX_DRONES) : dc_q;
  end

  assign busy_o = 1'b0;

  // ---------------- drones per circle: (dc + nc - 1) / nc ----------------
  localparam int PSW = TimeW + IdW;
  logic             p_v    [PnumW+1];
  logic [PnumW-1:0] p_num  [PnumW+1];
  logic [NcW-1:0]   p_rem  [PnumW+1];
  logic [PSW-1:0]   p_side [PnumW+1];

  assign p_v[0]    = start_i && !busy_o;
  assign p_num[0]  = PnumW'(dc_eff) + PnumW'(nc_eff) - PnumW'(1);
  assign p_rem[0]  = '0;
  assign p_side[0] = {time_seconds_i, drone_id_i};

  for (genvar g = 0; g < PnumW; g++) begin : g_per
    cep_div_cell #(.NW(PnumW), .DW(NcW), .SW(PSW)) u_cell (
      .clk_i, .rst_ni,
      .valid_i(p_v[g]), .num_i(p_num[g]), .rem_i(p_rem[g]), .div_i(nc_eff),
      .side_i(p_side[g]),
      .valid_o(p_v[g+1]), .num_o(p_num[g+1]), .rem_o(p_rem[g+1]),
      .side_o(p_side[g+1])
    );
  end

  // ---------------- big index and slot: id / per ----------------
  localparam int QSW = TimeW + IdW + PerW;
  logic            q_v    [IdW+1];
  logic [IdW-1:0]  q_num  [IdW+1];
  logic [PerW-1:0] q_rem  [IdW+1];
  logic [QSW-1:0]  q_side [IdW+1];
  logic [PerW-1:0] per_in;

  assign per_in    = (p_num[PnumW] == '0) ? PerW'(1) : p_num[PnumW][PerW-1:0];
  assign q_v[0]    = p_v[PnumW];
  assign q_num[0]  = p_side[PnumW][IdW-1:0];
  assign q_rem[0]  = '0;
  assign q_side[0] = {p_side[PnumW], per_in};

  for (genvar g = 0; g < IdW; g++) begin : g_slot
    cep_div_cell #(.NW(IdW), .DW(PerW), .SW(QSW)) u_cell (
      .clk_i, .rst_ni,
      .valid_i(q_v[g]), .num_i(q_num[g]), .rem_i(q_rem[g]),
      .div_i(q_side[g][PerW-1:0]), .side_i(q_side[g]),
      .valid_o(q_v[g+1]), .num_o(q_num[g+1]), .rem_o(q_rem[g+1]),
      .side_o(q_side[g+1])
    );
  end

  // ---------------- index * length, small radius ----------------
  logic                   m_v_q;
  logic [LenProdW-1:0]    m_a_q, m_b_q, m_a_d, m_b_d;
  logic [TimeW-1:0]       m_t_q;
  logic [IdW-1:0]         m_id_q, q_id;
  logic [PerW-1:0]        m_per_q;
  logic signed [RadW-1:0] m_r2e_q, m_r2e_d;

  always_comb begin
    q_id    = q_side[IdW][PerW +: IdW];
    m_a_d   = LenProdW'(q_num[IdW]) * LenProdW'(len1);
    m_b_d   = LenProdW'(q_rem[IdW]) * LenProdW'(len2);
    m_r2e_d = $signed({4'b0000, r2, 3'b000}) + (rad_off_q * $signed({1'b0, q_id}));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q <= 1'b0;
    end else begin
      m_v_q <= q_v[IdW];
    end
  end

  always_ff @(posedge clk_i) begin
    m_a_q   <= m_a_d;
    m_b_q   <= m_b_d;
    m_t_q   <= q_side[IdW][PerW+IdW +: TimeW];
    m_id_q  <= q_id;
    m_per_q <= q_side[IdW][PerW-1:0];
    m_r2e_q <= m_r2e_d;
  end

  // ---------------- phase offsets: (index * length << 17) / count ----------------
  localparam int RSW = TimeW + IdW + RadW;
  logic              ra_v    [PhNumW+1];
  logic [PhNumW-1:0] ra_num  [PhNumW+1];
  logic [NcW-1:0]    ra_rem  [PhNumW+1];
  logic [RSW-1:0]    ra_side [PhNumW+1];
  logic              rb_v    [PhNumW+1];
  logic [PhNumW-1:0] rb_num  [PhNumW+1];
  logic [PerW-1:0]   rb_rem  [PhNumW+1];
  logic [PerW-1:0]   rb_side [PhNumW+1];

  assign ra_v[0]    = m_v_q;
  assign ra_num[0]  = {m_a_q, 17'b0};
  assign ra_rem[0]  = '0;
  assign ra_side[0] = {m_t_q, m_id_q, m_r2e_q};
  assign rb_v[0]    = m_v_q;
  assign rb_num[0]  = {m_b_q, 17'b0};
  assign rb_rem[0]  = '0;
  assign rb_side[0] = m_per_q;

  for (genvar g = 0; g < PhNumW; g++) begin : g_phase
    cep_div_cell #(.NW(PhNumW), .DW(NcW), .SW(RSW)) u_big (
      .clk_i, .rst_ni,
      .valid_i(ra_v[g]), .num_i(ra_num[g]), .rem_i(ra_rem[g]), .div_i(nc_eff),
      .side_i(ra_side[g]),
      .valid_o(ra_v[g+1]), .num_o(ra_num[g+1]), .rem_o(ra_rem[g+1]),
      .side_o(ra_side[g+1])
    );
    cep_div_cell #(.NW(PhNumW), .DW(PerW), .SW(PerW)) u_small (
      .clk_i, .rst_ni,
      .valid_i(rb_v[g]), .num_i(rb_num[g]), .rem_i(rb_rem[g]), .div_i(rb_side[g]),
      .side_i(rb_side[g]),
      .valid_o(rb_v[g+1]), .num_o(rb_num[g+1]), .rem_o(rb_rem[g+1]),
      .side_o(rb_side[g+1])
    );
  end

  // ---------------- time * speed ----------------
  logic                   h1_v_q;
  logic [31:0]            h1_qa_q, h1_qb_q;
  logic [TsW-1:0]         h1_tsa_q, h1_tsb_q;
  logic [IdW-1:0]         h1_id_q;
  logic signed [RadW-1:0] h1_r2e_q;
  logic signed [48:0]     prod_a, prod_b;
  logic [TimeW-1:0]       r_t;

  always_comb begin
    r_t    = ra_side[PhNumW][IdW+RadW +: TimeW];
    prod_a = $signed({1'b0, r_t}) * speed1;
    prod_b = $signed({1'b0, r_t}) * speed2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h1_v_q <= 1'b0;
    end else begin
      h1_v_q <= ra_v[PhNumW] && rb_v[PhNumW];
    end
  end

  always_ff @(posedge clk_i) begin
    h1_qa_q  <= ra_num[PhNumW][31:0];
    h1_qb_q  <= rb_num[PhNumW][31:0];
    h1_tsa_q <= prod_a[TsW-1:0];
    h1_tsb_q <= prod_b[TsW-1:0];
    h1_id_q  <= ra_side[PhNumW][RadW +: IdW];
    h1_r2e_q <= ra_side[PhNumW][RadW-1:0];
  end

  // ---------------- phase sum, angle in 16-bit turns ----------------
  logic                   h2_v_q;
  logic [15:0]            h2_aa_q, h2_ab_q;
  logic [IdW-1:0]         h2_id_q;
  logic signed [RadW-1:0] h2_r2e_q;
  logic [31:0]            pa, pb;

  always_comb begin
    pa = {start1[14:0], 17'b0} + h1_qa_q + {h1_tsa_q, 3'b000};
    pb = {start2[14:0], 17'b0} + h1_qb_q + {h1_tsb_q, 3'b000};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h2_v_q <= 1'b0;
    end else begin
      h2_v_q <= h1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    h2_aa_q  <= pa[31:16];
    h2_ab_q  <= pb[31:16];
    h2_id_q  <= h1_id_q;
    h2_r2e_q <= h1_r2e_q;
  end

  // ---------------- CORDIC chain ----------------
  localparam int CSW = IdW + RadW + 4;
  logic               c_v    [CordicSteps+1];
  cordic_lane_t [1:0] c_lane [CordicSteps+1];
  logic [CSW-1:0]     c_side [CordicSteps+1];

  always_comb begin
    c_v[0]         = h2_v_q;
    c_lane[0][0].x = CordicGain;
    c_lane[0][0].y = '0;
    c_lane[0][0].z = {2'b00, h2_aa_q[13:0]};
    c_lane[0][1].x = CordicGain;
    c_lane[0][1].y = '0;
    c_lane[0][1].z = {2'b00, h2_ab_q[13:0]};
    c_side[0]      = {h2_id_q, h2_r2e_q, h2_aa_q[15:14], h2_ab_q[15:14]};
  end

  for (genvar g = 0; g < CordicSteps; g++) begin : g_cordic
    cep_cordic_cell #(.Step(g), .SW(CSW)) u_cell (
      .clk_i, .rst_ni,
      .valid_i(c_v[g]), .lane_i(c_lane[g]), .side_i(c_side[g]),
      .valid_o(c_v[g+1]), .lane_o(c_lane[g+1]), .side_o(c_side[g+1])
    );
  end

  // ---------------- quadrant fold ----------------
  logic                    f1_v_q;
  logic signed [CordW-1:0] cos_d [2];
  logic signed [CordW-1:0] sin_d [2];
  logic signed [CordW-1:0] f1_cos_q [2];
  logic signed [CordW-1:0] f1_sin_q [2];
  logic [IdW-1:0]          f1_id_q;
  logic signed [RadW-1:0]  f1_r2e_q;
  logic [1:0]              quad [2];

  always_comb begin
    quad[0] = c_side[CordicSteps][3:2];
    quad[1] = c_side[CordicSteps][1:0];
    for (int l = 0; l < 2; l++) begin
      case (quad[l])
        2'd0: begin
          cos_d[l] = c_lane[CordicSteps][l].x;
          sin_d[l] = c_lane[CordicSteps][l].y;
        end
        2'd1: begin
          cos_d[l] = -c_lane[CordicSteps][l].y;
          sin_d[l] = c_lane[CordicSteps][l].x;
        end
        2'd2: begin
          cos_d[l] = -c_lane[CordicSteps][l].x;
          sin_d[l] = -c_lane[CordicSteps][l].y;
        end
        default: begin
          cos_d[l] = c_lane[CordicSteps][l].y;
          sin_d[l] = -c_lane[CordicSteps][l].x;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_v_q <= 1'b0;
    end else begin
      f1_v_q <= c_v[CordicSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    f1_cos_q <= cos_d;
    f1_sin_q <= sin_d;
    f1_id_q  <= c_side[CordicSteps][CSW-1 -: IdW];
    f1_r2e_q <= c_side[CordicSteps][4 +: RadW];
  end

  // ---------------- products ----------------
  logic                      f2_v_q;
  logic signed [48:0]        f2_c1_q, f2_s1_q;
  logic signed [54:0]        f2_c2_q, f2_s2_q;
  logic signed [CenOffW-1:0] f2_co_q [3];
  logic signed [CenOffW-1:0] co_d [3];
  logic signed [15:0]        cen_k, off_k;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cen_k   = center_q[16*k +: 16];
      off_k   = idoff_q[16*k +: 16];
      co_d[k] = cen_k + off_k * $signed({1'b0, f1_id_q});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f2_v_q <= 1'b0;
    end else begin
      f2_v_q <= f1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    f2_c1_q <= f1_cos_q[0] * $signed({1'b0, r1});
    f2_s1_q <= f1_sin_q[0] * $signed({1'b0, r1});
    f2_c2_q <= f1_cos_q[1] * f1_r2e_q;
    f2_s2_q <= f1_sin_q[1] * f1_r2e_q;
    f2_co_q <= co_d;
  end

  // ---------------- accumulate with rounding bias ----------------
  logic                   f3_v_q;
  logic signed [AccW-1:0] f3_acc_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f3_v_q <= 1'b0;
    end else begin
      f3_v_q <= f2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    f3_acc_q[0] <= (AccW'(f2_co_q[0]) <<< 37) + (AccW'(f2_c1_q) <<< 3)
                   + AccW'(f2_c2_q) + RoundBias;
    f3_acc_q[1] <= (AccW'(f2_co_q[1]) <<< 37) + RoundBias;
    f3_acc_q[2] <= (AccW'(f2_co_q[2]) <<< 37) + (AccW'(f2_s1_q) <<< 3)
                   + AccW'(f2_s2_q) + RoundBias;
  end

  // ---------------- scale, saturate, output register ----------------
  logic                     out_v_q;
  logic signed [CoordW-1:0] pos_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= f3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      pos_q[k] <= sat16(f3_acc_q[k][63:37]);
    end
  end

  assign valid_o = out_v_q;
  assign pos_x_o = pos_q[0];
  assign pos_y_o = pos_q[1];
  assign pos_z_o = pos_q[2];

`ifndef SYNTHESIS
  a_result_follows_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start_i && !busy_o, Latency))
    else $error("result without a matching start");

  a_per_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_v[PnumW] |-> (per_in != '0))
    else $error("drones per circle is zero");

  a_slot_below_per: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_v[IdW] |-> (q_rem[IdW] < q_side[IdW][PerW-1:0]))
    else $error("slot not below drones per circle");
`endif

endmodule

[src/cep_div_cell.sv]
// ----------------------------------------------------------------------------
// cep_div_cell: one restoring division step
// Shifts one numerator bit into the partial remainder, sets one quotient bit
// and registers the lot, with side data, for the next cell.
// ----------------------------------------------------------------------------
module cep_div_cell #(
  parameter int NW = 8,
  parameter int DW = 4,
  parameter int SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] rem_i,
  input  logic [DW-1:0] div_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [NW-1:0] num_o,
  output logic [DW-1:0] rem_o,
  output logic [SW-1:0] side_o
);
  import cep_pkg::*;

  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          take;
  logic          valid_q;
  logic [NW-1:0] num_q, num_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [SW-1:0] side_q;

  always_comb begin
    trial = {rem_i, num_i[NW-1]};
    diff  = trial - {1'b0, div_i};
    take  = (trial >= {1'b0, div_i});
    rem_d = take ? diff[DW-1:0] : trial[DW-1:0];
    // numerator drains from the top, quotient fills from the bottom
    num_d = {num_i[NW-2:0], take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    rem_q  <= rem_d;
    side_q <= side_i;
  end

  assign valid_o = valid_q;
  assign num_o   = num_q;
  assign rem_o   = rem_q;
  assign side_o  = side_q;

endmodule

[src/cep_cordic_cell.sv]
// ----------------------------------------------------------------------------
// cep_cordic_cell: one rotation step for two angle lanes
// Fixed shift per cell; rotates towards zero residual angle.
// ----------------------------------------------------------------------------
module cep_cordic_cell #(
  parameter int Step = 0,
  parameter int SW   = 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  cep_pkg::cordic_lane_t [1:0]   lane_i,
  input  logic [SW-1:0]                 side_i,
  output logic                          valid_o,
  output cep_pkg::cordic_lane_t [1:0]   lane_o,
  output logic [SW-1:0]                 side_o
);
  import cep_pkg::*;

  localparam logic signed [ZW-1:0] Angle = atan_turns(Step);

  logic signed [CordW-1:0] dx [2];
  logic signed [CordW-1:0] dy [2];
  cordic_lane_t [1:0]      lane_d, lane_q;
  logic                    valid_q;
  logic [SW-1:0]           side_q;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      dx[l] = lane_i[l].y >>> Step;
      dy[l] = lane_i[l].x >>> Step;
      if (!lane_i[l].z[ZW-1]) begin
        lane_d[l].x = lane_i[l].x - dx[l];
        lane_d[l].y = lane_i[l].y + dy[l];
        lane_d[l].z = lane_i[l].z - Angle;
      end else begin
        lane_d[l].x = lane_i[l].x + dx[l];
        lane_d[l].y = lane_i[l].y - dy[l];
        lane_d[l].z = lane_i[l].z + Angle;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    lane_q <= lane_d;
    side_q <= side_i;
  end

  assign valid_o = valid_q;
  assign lane_o  = lane_q;
  assign side_o  = side_q;

endmodule

[tb/circle_epicycle_position_tb.sv]
// ----------------------------------------------------------------------------
// circle_epicycle_position_tb: self-checking bench for the epicycle position block
// Drives (time, id) queries under several register settings and idle mixes,
// predicts each position with an independent CORDIC model and compares.
// ----------------------------------------------------------------------------
module circle_epicycle_position_tb;
  import cep_pkg::*;

  localparam int LatencyCycles = 75;
  localparam int WatchdogLimit = 2000;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } position_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start_i = 1'b0;
  logic              busy_o;
  logic [TimeW-1:0]  time_seconds_i = '0;
  logic [IdW-1:0]    drone_id_i = '0;
  logic              valid_o;
  logic signed [15:0] pos_x_o, pos_y_o, pos_z_o;
  logic              cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;

  // shadow registers
  logic [3:0]  sh_nc;
  logic [6:0]  sh_dc;
  logic [47:0] sh_center;
  logic [63:0] sh_big;
  logic [63:0] sh_small;
  logic [47:0] sh_off;
  logic [15:0] sh_roff;

  position_t expected_positions[$];
  int        error_count = 0;
  int        idle_cycles = 0;
  int        send_idle_pct = 0;

  always #5 clk_i = ~clk_i;

  circle_epicycle_position DUT (
    .clk_i, .rst_ni, .start_i, .busy_o, .time_seconds_i, .drone_id_i,
    .valid_o, .pos_x_o, .pos_y_o, .pos_z_o, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i
  );

  function automatic longint atan_step(int i);
    case (i)
      0: return 8192;  1: return 4836; 2: return 2555; 3: return 1297;
      4: return 651;   5: return 326;  6: return 163;  7: return 81;
      8: return 41;    9: return 20;   10: return 10;  11: return 5;
      12: return 3;    default: return 1;
    endcase
  endfunction

  task automatic rotate_angle(input logic [15:0] ang, output longint c, output longint s);
    longint x, y, z, dx, dy;
    x = 652032874; y = 0; z = ang[13:0];
    for (int i = 0; i < CordicSteps; i++) begin
      dx = y >>> i; dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_step(i);
      end else begin
        x += dx; y -= dy; z += atan_step(i);
      end
    end
    case (ang[15:14])
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endtask

  function automatic logic [15:0] circle_angle(logic [63:0] set, longint idx, longint cnt,
                                               logic [31:0] t);
    logic [63:0] p, num;
    longint speed;
    speed = $signed(set[47:32]);
    p = {47'd0, set[31:16], 1'b0} << 16;
    num = (64'(idx) * 64'(set[63:48])) << 17;
    p += num / 64'(cnt);
    p += (64'(t) * 64'(speed)) << 3;
    return p[31:16];
  endfunction

  function automatic logic signed [15:0] round_sat(longint acc);
    longint v;
    v = (acc + (longint'(1) << 36)) >>> 37;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  task automatic predict_position(input logic [31:0] t, input logic [5:0] id,
                                  output position_t p);
    longint nc, dc, per, big, slot, c1, s1, c2, s2, r1, r2e, cen, off;
    longint acc[3];
    nc = sh_nc; dc = sh_dc;
    if (nc == 0) nc = 1;
    if (nc > 10) nc = 10;
    if (dc > 64) dc = 64;
    per = (dc + nc - 1) / nc;
    if (per < 1) per = 1;
    big = id / per; slot = id % per;
    rotate_angle(circle_angle(sh_big, big, nc, t), c1, s1);
    rotate_angle(circle_angle(sh_small, slot, per, t), c2, s2);
    r1 = sh_big[15:0];
    r2e = longint'(sh_small[15:0]) * 8 + longint'($signed(sh_roff)) * longint'(id);
    for (int k = 0; k < 3; k++) begin
      cen = $signed(sh_center[16*k +: 16]);
      off = $signed(sh_off[16*k +: 16]);
      acc[k] = (cen + off * longint'(id)) * (longint'(1) << 37);
    end
    acc[0] += c1 * r1 * 8 + c2 * r2e;
    acc[2] += s1 * r1 * 8 + s2 * r2e;
    p.x = round_sat(acc[0]); p.y = round_sat(acc[1]); p.z = round_sat(acc[2]);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    error_count++;
  endtask

  // result checker
  always @(posedge clk_i) begin
    position_t e;
    if (rst_ni && valid_o) begin
      if (expected_positions.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        e = expected_positions.pop_front();
        if (pos_x_o !== e.x) report_mismatch("pos_x", pos_x_o, e.x);
        if (pos_y_o !== e.y) report_mismatch("pos_y", pos_y_o, e.y);
        if (pos_z_o !== e.z) report_mismatch("pos_z", pos_z_o, e.z);
      end
    end
  end

  // watchdog: cycles with no start, result or write while results are pending
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || valid_o || cfg_we_i || expected_positions.size() == 0)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("watchdog expired");
      $display("== FAIL ==");
      $finish;
    end
  end

  // one register write; the enable drops before the next write
  task automatic write_reg(input cfg_reg_e idx, input logic [63:0] val);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      REG_NUM_CIRCLES:   sh_nc = val[3:0];
      REG_DRONE_COUNT:   sh_dc = val[6:0];
      REG_CENTER_XYZ:    sh_center = val[47:0];
      REG_BIG_CIRCLE:    sh_big = val;
      REG_SMALL_CIRCLE:  sh_small = val;
      REG_ID_OFFSET_XYZ: sh_off = val[47:0];
      REG_RADIUS_OFFSET: sh_roff = val[15:0];
      default: ;
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // one query; the start stays high across back-to-back transactions
  task automatic send_query(input logic [31:0] t, input logic [5:0] id);
    position_t p;
    while ($urandom_range(99) < send_idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1; time_seconds_i <= t; drone_id_i <= id;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    predict_position(t, id, p);
    expected_positions.push_back(p);
  endtask

  task automatic drain;
    start_i <= 1'b0;
    while (expected_positions.size() != 0) @(posedge clk_i);
    repeat (LatencyCycles + 5) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_time();
    case ($urandom_range(3))
      0: return $urandom_range(65535);
      1: return 32'hFFFF_FFFF - $urandom_range(255);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_defaults;
    send_query(32'd0, 6'd0);
    send_query(32'hFFFF_FFFF, 6'd63);
    send_query(32'h0001_0000, 6'd1);
    send_query(32'h0000_8000, 6'd0);
    drain();
  endtask

  task automatic test_directed_extremes;
    write_reg(REG_NUM_CIRCLES, 64'd0);            // zero circles
    write_reg(REG_DRONE_COUNT, 64'd0);
    write_reg(REG_CENTER_XYZ, 64'h7FFF_8000_7FFF);
    write_reg(REG_BIG_CIRCLE, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_SMALL_CIRCLE, 64'hFFFF_7FFF_FFFF_FFFF);
    write_reg(REG_ID_OFFSET_XYZ, 64'h7FFF_8000_7FFF);
    write_reg(REG_RADIUS_OFFSET, 64'h8000);
    write_reg(cfg_reg_e'(3'd7), 64'hFFFF_FFFF_FFFF_FFFF);  // unmapped index
    send_query(32'd0, 6'd63);
    send_query(32'hFFFF_FFFF, 6'd0);
    drain();
    write_reg(REG_NUM_CIRCLES, 64'd15);           // above the circle limit
    write_reg(REG_DRONE_COUNT, 64'd127);          // above the drone limit
    write_reg(REG_CENTER_XYZ, 64'h8000_7FFF_8000);
    write_reg(REG_BIG_CIRCLE, 64'h7FFF_8000_0000_FFFF);
    write_reg(REG_SMALL_CIRCLE, 64'h0000_0000_8000_0000);
    write_reg(REG_ID_OFFSET_XYZ, 64'h8000_7FFF_8000);
    write_reg(REG_RADIUS_OFFSET, 64'h7FFF);
    for (int i = 0; i < 6; i++) send_query(rand_time(), 6'(i * 13));
    drain();
    write_reg(REG_NUM_CIRCLES, 64'd3);            // ids beyond the group
    write_reg(REG_DRONE_COUNT, 64'd5);
    write_reg(REG_ID_OFFSET_XYZ, 64'd0);
    write_reg(REG_CENTER_XYZ, 64'd0);
    for (int i = 0; i < 6; i++) send_query(rand_time(), 6'(58 + i));
    drain();
  endtask

  task automatic test_random_settings(input int idle_pct, input int n);
    send_idle_pct = idle_pct;
    write_reg(REG_NUM_CIRCLES, 64'($urandom_range(15)));
    write_reg(REG_DRONE_COUNT, 64'($urandom_range(127)));
    write_reg(REG_CENTER_XYZ, {$urandom, $urandom});
    write_reg(REG_BIG_CIRCLE, {$urandom, $urandom});
    write_reg(REG_SMALL_CIRCLE, {$urandom, $urandom});
    write_reg(REG_ID_OFFSET_XYZ, $urandom_range(1) ? {$urandom, $urandom} :
                                 64'($urandom_range(255)));
    write_reg(REG_RADIUS_OFFSET, 64'($urandom));
    for (int i = 0; i < n; i++) send_query(rand_time(), 6'($urandom));
    drain();
  endtask

  initial begin
    sh_nc = 4'd1; sh_dc = 7'd1; sh_center = 48'h0000_0080_0000;
    sh_big = 64'h8000_0000_0000_0000; sh_small = 64'h8000_0333_0000_04CD;
    sh_off = '0; sh_roff = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_defaults();
    test_directed_extremes();
    for (int ph = 0; ph < 16; ph++) begin
      case (ph % 4)
        0: test_random_settings(0, 40);
        1: test_random_settings(57, 40);
        2: test_random_settings(35, 40);
        default: test_random_settings($urandom_range(10), 40);
      endcase
    end
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[circle_epicycle_position.f]
src/cep_pkg.sv
src/cep_div_cell.sv
src/cep_cordic_cell.sv
src/circle_epicycle_position.sv
tb/circle_epicycle_position_tb.sv
